### hw/rtl/acts_pkg.sv
// ----------------------------------------------------------------------------
// acts_pkg
// Shared types, codes and helpers of the alarm clock with time setting.
// ----------------------------------------------------------------------------
`default_nettype none

package acts_pkg;

   // Display modes
   localparam logic [1:0] MODE_SHOW  = 2'd0;
   localparam logic [1:0] MODE_TIME  = 2'd1;
   localparam logic [1:0] MODE_ALARM = 2'd2;

   // Transaction kinds
   localparam logic CMD_TICK = 1'b0;
   localparam logic CMD_KEY  = 1'b1;

   // Key codes
   localparam logic [3:0] KEY_NONE   = 4'd0;
   localparam logic [3:0] KEY_TIME   = 4'd1;
   localparam logic [3:0] KEY_ALARM  = 4'd2;
   localparam logic [3:0] KEY_NEXT   = 4'd3;
   localparam logic [3:0] KEY_UP     = 4'd5;
   localparam logic [3:0] KEY_DEC    = 4'd6;
   localparam logic [3:0] KEY_SAVE   = 4'd7;
   localparam logic [3:0] KEY_CANCEL = 4'd8;

   // Field selectors
   localparam logic [1:0] SEL_HOURS   = 2'd0;
   localparam logic [1:0] SEL_MINUTES = 2'd1;
   localparam logic [1:0] SEL_SECONDS = 2'd2;

   // Configuration register indexes
   localparam logic CSR_TICKS_PER_SECOND  = 1'b0;
   localparam logic CSR_BLINK_HALF_PERIOD = 1'b1;

   localparam int CSR_DATA_W = 16;

   localparam logic [15:0] TICKS_PER_SECOND_RST  = 16'd1000;
   localparam logic [15:0] BLINK_HALF_PERIOD_RST = 16'd250;

   localparam logic [5:0] HOURS_PER_DAY    = 6'd24;
   localparam logic [5:0] MINUTES_PER_HOUR = 6'd60;
   localparam logic [4:0] NOON_HOUR        = 5'd12;
   localparam logic [3:0] BLANK_DIGIT      = 4'd10;

   localparam logic [7:0] LED_OFF = 8'hFF;
   localparam logic [7:0] LED_AM  = 8'h0F;
   localparam logic [7:0] LED_PM  = 8'hF0;

   // Reset values of the time of day
   localparam logic [4:0] HOURS_RST   = 5'd23;
   localparam logic [5:0] MINUTES_RST = 6'd59;
   localparam logic [5:0] SECONDS_RST = 6'd55;

   typedef struct packed {
      logic       command;
      logic [3:0] key_code;
   } req_payload_type;

   typedef struct packed {
      logic [3:0] digit_hour_tens;
      logic [3:0] digit_hour_units;
      logic [3:0] digit_minute_tens;
      logic [3:0] digit_minute_units;
      logic [3:0] digit_second_tens;
      logic [3:0] digit_second_units;
      logic [1:0] mode;
      logic       alarm_ringing;
      logic       relay_drive_n;
      logic [7:0] led_drive_n;
   } rsp_payload_type;

   // Step one hh/mm/ss field up or down with wrap; the limit follows sel.
   function automatic logic [5:0] step_field(input logic [5:0] value,
                                             input logic [1:0] sel,
                                             input logic       up);
      logic [5:0] lim;
      logic [6:0] inc;
      lim = (sel == SEL_HOURS) ? HOURS_PER_DAY : MINUTES_PER_HOUR;
      inc = {1'b0, value} + 7'd1;
      if (up) begin
         step_field = (inc >= {1'b0, lim}) ? 6'd0 : inc[5:0];
      end else begin
         step_field = (value == 6'd0 || value > lim) ? lim - 6'd1 : value - 6'd1;
      end
   endfunction

   // Tens digit of a value below 64.
   function automatic logic [3:0] digit_tens(input logic [5:0] value);
      if      (value >= 6'd60) digit_tens = 4'd6;
      else if (value >= 6'd50) digit_tens = 4'd5;
      else if (value >= 6'd40) digit_tens = 4'd4;
      else if (value >= 6'd30) digit_tens = 4'd3;
      else if (value >= 6'd20) digit_tens = 4'd2;
      else if (value >= 6'd10) digit_tens = 4'd1;
      else                     digit_tens = 4'd0;
   endfunction

   function automatic logic [3:0] digit_units(input logic [5:0] value);
      logic [5:0] tens_x10;
      tens_x10 = {2'b00, digit_tens(value)} * 6'd10;
      digit_units = 4'(value - tens_x10);
   endfunction

endpackage

`default_nettype wire

### hw/rtl/acts_chan_if.sv
// ----------------------------------------------------------------------------
// acts_chan_if
// Valid/ready channel carrying one payload struct per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface acts_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

### hw/rtl/alarm_clock_with_time_setting_unit.sv
// ----------------------------------------------------------------------------
// alarm_clock_with_time_setting_unit
// Digital alarm clock: time keeping, time/alarm setting, display and alarm.
// ----------------------------------------------------------------------------
// Each request transaction is a tick (command 0) or a key press (command 1)
// and yields exactly one response transaction with six display digits
// (10 = blank), the mode, the ringing flag, the relay drive and the LED byte.
// The block takes one request per clock cycle unless backpressure stalls it: a
// request is captured in an input register, then the time/edit/alarm state is
// updated and the response is captured in the output register when the item
// advances. Both registers move independently; backpressure on rsp_chan only
// stalls once both are full.
// csr_write_en writes ticks_per_second (index 0) or blink_half_period
// (index 1); write these only while no transaction is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module alarm_clock_with_time_setting_unit (
   input  wire logic                             clock,
   input  wire logic                             reset,
   acts_chan_if.sink                             req_chan,
   acts_chan_if.source                           rsp_chan,
   input  wire logic                             csr_write_en,
   input  wire logic                             csr_index,
   input  wire logic [acts_pkg::CSR_DATA_W-1:0]  csr_data
);

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [15:0] ticks_per_second_ff;
   logic [15:0] blink_half_period_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_per_second_ff  <= acts_pkg::TICKS_PER_SECOND_RST;
         blink_half_period_ff <= acts_pkg::BLINK_HALF_PERIOD_RST;
      end else if (csr_write_en) begin
         case (csr_index)
            acts_pkg::CSR_TICKS_PER_SECOND:  ticks_per_second_ff  <= csr_data;
            acts_pkg::CSR_BLINK_HALF_PERIOD: blink_half_period_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Input register and handshake
   // ---------------------------------------------------------------------
   logic                      in_valid_ff;
   acts_pkg::req_payload_type in_item_ff;
   logic                      rsp_valid_ff;
   acts_pkg::rsp_payload_type rsp_item_ff;
   logic                      advance;    // item moves from input to output reg

   assign advance        = in_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_item_ff <= req_chan.payload;
      end
   end

   // ---------------------------------------------------------------------
   // Clock state
   // ---------------------------------------------------------------------
   logic [4:0]  hours_ff,        hours_in;
   logic [5:0]  minutes_ff,      minutes_in;
   logic [5:0]  seconds_ff,      seconds_in;
   logic [15:0] tick_count_ff,   tick_count_in;
   logic [15:0] blink_count_ff,  blink_count_in;
   logic        blink_phase_ff,  blink_phase_in;
   logic [1:0]  mode_ff,         mode_in;
   logic [5:0]  edit_ff  [3];
   logic [5:0]  edit_in  [3];
   logic [1:0]  edit_sel_ff,     edit_sel_in;
   logic [5:0]  alarm_ff [3];
   logic [5:0]  alarm_in [3];
   logic [1:0]  alarm_sel_ff,    alarm_sel_in;
   logic        alarm_flag_ff,   alarm_flag_in;

   logic [16:0] tick_next;
   logic [16:0] blink_next;
   logic [6:0]  sec_inc;
   logic [6:0]  min_inc;
   logic [5:0]  hour_inc;
   logic        alarm_match;

   assign tick_next  = {1'b0, tick_count_ff}  + 17'd1;
   assign blink_next = {1'b0, blink_count_ff} + 17'd1;

   always_comb begin
      hours_in       = hours_ff;
      minutes_in     = minutes_ff;
      seconds_in     = seconds_ff;
      tick_count_in  = tick_count_ff;
      blink_count_in = blink_count_ff;
      blink_phase_in = blink_phase_ff;
      mode_in        = mode_ff;
      edit_in        = edit_ff;
      edit_sel_in    = edit_sel_ff;
      alarm_in       = alarm_ff;
      alarm_sel_in   = alarm_sel_ff;
      alarm_flag_in  = alarm_flag_ff;
      sec_inc        = {1'b0, seconds_ff} + 7'd1;
      min_inc        = {1'b0, minutes_ff} + 7'd1;
      hour_inc       = {1'b0, hours_ff} + 6'd1;

      if (in_item_ff.command == acts_pkg::CMD_TICK) begin
         // blink timebase
         if (blink_next >= {1'b0, blink_half_period_ff}) begin
            blink_count_in = '0;
            blink_phase_in = !blink_phase_ff;
         end else begin
            blink_count_in = blink_next[15:0];
         end
         // seconds timebase and hh:mm:ss carry chain
         if (tick_next >= {1'b0, ticks_per_second_ff}) begin
            tick_count_in = '0;
            if (sec_inc >= {1'b0, acts_pkg::MINUTES_PER_HOUR}) begin
               seconds_in = '0;
               if (min_inc >= {1'b0, acts_pkg::MINUTES_PER_HOUR}) begin
                  minutes_in = '0;
                  hours_in   = (hour_inc >= acts_pkg::HOURS_PER_DAY) ? 5'd0
                                                                    : hour_inc[4:0];
               end else begin
                  minutes_in = min_inc[5:0];
               end
            end else begin
               seconds_in = sec_inc[5:0];
            end
         end else begin
            tick_count_in = tick_next[15:0];
         end
      end else if (in_item_ff.key_code != acts_pkg::KEY_NONE) begin
         // any real key silences the alarm
         alarm_flag_in = 1'b0;
         case (in_item_ff.key_code)
            acts_pkg::KEY_TIME: begin
               if (mode_ff == acts_pkg::MODE_SHOW) begin
                  edit_in[0] = {1'b0, hours_ff};
                  edit_in[1] = minutes_ff;
                  edit_in[2] = seconds_ff;
                  mode_in    = acts_pkg::MODE_TIME;
               end
            end
            acts_pkg::KEY_ALARM: begin
               if (mode_ff == acts_pkg::MODE_SHOW) mode_in = acts_pkg::MODE_ALARM;
            end
            acts_pkg::KEY_NEXT: begin
               if (mode_ff == acts_pkg::MODE_TIME) begin
                  edit_sel_in = (edit_sel_ff >= acts_pkg::SEL_SECONDS)
                                ? acts_pkg::SEL_HOURS : edit_sel_ff + 2'd1;
               end else if (mode_ff == acts_pkg::MODE_ALARM) begin
                  alarm_sel_in = (alarm_sel_ff >= acts_pkg::SEL_SECONDS)
                                 ? acts_pkg::SEL_HOURS : alarm_sel_ff + 2'd1;
               end
            end
            acts_pkg::KEY_UP, acts_pkg::KEY_DEC: begin
               for (int i = 0; i < 3; i++) begin
                  if (mode_ff == acts_pkg::MODE_TIME && edit_sel_ff == 2'(i)) begin
                     edit_in[i] = acts_pkg::step_field(edit_ff[i], edit_sel_ff,
                        in_item_ff.key_code == acts_pkg::KEY_UP);
                  end
                  if (mode_ff == acts_pkg::MODE_ALARM && alarm_sel_ff == 2'(i)) begin
                     alarm_in[i] = acts_pkg::step_field(alarm_ff[i], alarm_sel_ff,
                        in_item_ff.key_code == acts_pkg::KEY_UP);
                  end
               end
            end
            acts_pkg::KEY_SAVE: begin
               if (mode_ff == acts_pkg::MODE_TIME) begin
                  hours_in   = edit_ff[0][4:0];
                  minutes_in = edit_ff[1];
                  seconds_in = edit_ff[2];
                  mode_in    = acts_pkg::MODE_SHOW;
               end else if (mode_ff == acts_pkg::MODE_ALARM) begin
                  mode_in = acts_pkg::MODE_SHOW;
               end
            end
            acts_pkg::KEY_CANCEL: begin
               if (mode_ff == acts_pkg::MODE_TIME) begin
                  edit_in[0] = {1'b0, hours_ff};
                  edit_in[1] = minutes_ff;
                  edit_in[2] = seconds_ff;
                  mode_in    = acts_pkg::MODE_SHOW;
               end else if (mode_ff == acts_pkg::MODE_ALARM) begin
                  alarm_in[0] = '0;
                  alarm_in[1] = '0;
                  alarm_in[2] = '0;
                  mode_in     = acts_pkg::MODE_SHOW;
               end
            end
            default: ;
         endcase
      end

      // alarm compare on the updated time, after any key has cleared the flag
      alarm_match = ({1'b0, hours_in} == alarm_in[0]) && (minutes_in == alarm_in[1])
                    && (seconds_in == alarm_in[2]);
      if (alarm_match) alarm_flag_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hours_ff       <= acts_pkg::HOURS_RST;
         minutes_ff     <= acts_pkg::MINUTES_RST;
         seconds_ff     <= acts_pkg::SECONDS_RST;
         tick_count_ff  <= '0;
         blink_count_ff <= '0;
         blink_phase_ff <= 1'b0;
         mode_ff        <= acts_pkg::MODE_SHOW;
         edit_ff[0]     <= {1'b0, acts_pkg::HOURS_RST};
         edit_ff[1]     <= acts_pkg::MINUTES_RST;
         edit_ff[2]     <= acts_pkg::SECONDS_RST;
         edit_sel_ff    <= acts_pkg::SEL_HOURS;
         alarm_ff[0]    <= '0;
         alarm_ff[1]    <= '0;
         alarm_ff[2]    <= '0;
         alarm_sel_ff   <= acts_pkg::SEL_HOURS;
         alarm_flag_ff  <= 1'b0;
      end else if (advance) begin
         hours_ff       <= hours_in;
         minutes_ff     <= minutes_in;
         seconds_ff     <= seconds_in;
         tick_count_ff  <= tick_count_in;
         blink_count_ff <= blink_count_in;
         blink_phase_ff <= blink_phase_in;
         mode_ff        <= mode_in;
         edit_ff        <= edit_in;
         edit_sel_ff    <= edit_sel_in;
         alarm_ff       <= alarm_in;
         alarm_sel_ff   <= alarm_sel_in;
         alarm_flag_ff  <= alarm_flag_in;
      end
   end

   // ---------------------------------------------------------------------
   // Response formatting from the updated state
   // ---------------------------------------------------------------------
   logic [5:0]                shown [3];
   logic [1:0]                shown_sel;
   logic                      blank_on;
   logic [3:0]                tens  [3];
   logic [3:0]                units [3];
   acts_pkg::rsp_payload_type rsp_item_in;

   always_comb begin
      shown[0]  = {1'b0, hours_in};
      shown[1]  = minutes_in;
      shown[2]  = seconds_in;
      shown_sel = edit_sel_in;
      blank_on  = 1'b0;
      case (mode_in)
         acts_pkg::MODE_TIME: begin
            shown     = edit_in;
            shown_sel = edit_sel_in;
            blank_on  = !blink_phase_in;
         end
         acts_pkg::MODE_ALARM: begin
            shown     = alarm_in;
            shown_sel = alarm_sel_in;
            blank_on  = !blink_phase_in;
         end
         default: ;
      endcase

      for (int i = 0; i < 3; i++) begin
         if (blank_on && shown_sel == 2'(i)) begin
            tens[i]  = acts_pkg::BLANK_DIGIT;
            units[i] = acts_pkg::BLANK_DIGIT;
         end else begin
            tens[i]  = acts_pkg::digit_tens(shown[i]);
            units[i] = acts_pkg::digit_units(shown[i]);
         end
      end

      rsp_item_in.digit_hour_tens    = tens[0];
      rsp_item_in.digit_hour_units   = units[0];
      rsp_item_in.digit_minute_tens  = tens[1];
      rsp_item_in.digit_minute_units = units[1];
      rsp_item_in.digit_second_tens  = tens[2];
      rsp_item_in.digit_second_units = units[2];
      rsp_item_in.mode               = mode_in;
      rsp_item_in.alarm_ringing      = alarm_flag_in;
      rsp_item_in.relay_drive_n      = !alarm_flag_in;
      // AM/PM LED lit during the off blink phase while ringing
      if (alarm_flag_in && !blink_phase_in) begin
         rsp_item_in.led_drive_n = (alarm_in[0] < {1'b0, acts_pkg::NOON_HOUR})
                                   ? acts_pkg::LED_AM : acts_pkg::LED_PM;
      end else begin
         rsp_item_in.led_drive_n = acts_pkg::LED_OFF;
      end
   end

   // ---------------------------------------------------------------------
   // Output register
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_item_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   a_time_in_range: assert property (@(posedge clock) disable iff (reset)
      hours_ff < 5'd24 && minutes_ff < 6'd60 && seconds_ff < 6'd60)
      else $error("time of day out of range");

   a_select_in_range: assert property (@(posedge clock) disable iff (reset)
      edit_sel_ff <= acts_pkg::SEL_SECONDS && alarm_sel_ff <= acts_pkg::SEL_SECONDS)
      else $error("field selector out of range");

   a_match_rings: assert property (@(posedge clock) disable iff (reset)
      advance && alarm_match |=> alarm_flag_ff && rsp_chan.payload.alarm_ringing)
      else $error("alarm match did not raise the ringing flag");

   a_show_no_blank: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.payload.mode == acts_pkg::MODE_SHOW
      |-> rsp_chan.payload.digit_hour_tens != acts_pkg::BLANK_DIGIT
          && rsp_chan.payload.digit_second_units != acts_pkg::BLANK_DIGIT)
      else $error("blank digit while showing the clock");

endmodule

`default_nettype wire

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the alarm clock with time setting.
// ----------------------------------------------------------------------------
// Drives tick and key transactions into req_chan with bursty timing, stalls
// rsp_chan on a changing pattern (with one long hold-off per some phases) and
// compares every display transaction against an in-bench copy of the clock:
// time of day, edit and alarm copies, blink phase and the alarm flag. The
// tick and blink periods are rewritten between phases while the block idles.
// ----------------------------------------------------------------------------
`default_nettype none

import acts_pkg::*;

// Keeps its own copy of the clock state, predicts the display for every
// accepted request and checks responses in order.
class display_scoreboard;
   logic [15:0] tick_period, blink_period;
   logic [4:0]  hh;
   logic [5:0]  mm, ss;
   logic [15:0] tick_cnt, blink_cnt;
   logic        blink_on;
   logic [1:0]  mode;
   logic [5:0]  edit_f [3];
   logic [1:0]  edit_sel;
   logic [5:0]  alarm_f [3];
   logic [1:0]  alarm_sel;
   logic        ringing;

   rsp_payload_type expected_displays [$];
   int unsigned n_checked, n_ringing, n_mismatch, n_orphan, n_reported;

   function new();
      tick_period  = TICKS_PER_SECOND_RST;
      blink_period = BLINK_HALF_PERIOD_RST;
      hh = HOURS_RST;
      mm = MINUTES_RST;
      ss = SECONDS_RST;
      tick_cnt  = '0;
      blink_cnt = '0;
      blink_on  = 1'b0;
      mode      = MODE_SHOW;
      copy_clock_to_edit();
      edit_sel  = SEL_HOURS;
      alarm_f   = '{6'd0, 6'd0, 6'd0};
      alarm_sel = SEL_HOURS;
      ringing   = 1'b0;
   endfunction

   function void set_register(logic idx, logic [15:0] value);
      if (idx == CSR_TICKS_PER_SECOND) tick_period = value;
      else blink_period = value;
   endfunction

   function void copy_clock_to_edit();
      edit_f[0] = {1'b0, hh};
      edit_f[1] = mm;
      edit_f[2] = ss;
   endfunction

   function logic [1:0] next_sel(logic [1:0] s);
      return (s >= SEL_SECONDS) ? SEL_HOURS : s + 2'd1;
   endfunction

   // hours wrap at 24, minutes/seconds at 60
   function logic [5:0] wrap_step(logic [5:0] v, logic [1:0] sel, bit up);
      int lim;
      lim = (sel == SEL_HOURS) ? int'(HOURS_PER_DAY) : int'(MINUTES_PER_HOUR);
      if (up) return (int'(v) + 1 >= lim) ? 6'd0 : 6'(int'(v) + 1);
      return (v == 6'd0 || int'(v) > lim) ? 6'(lim - 1) : v - 6'd1;
   endfunction

   function void advance_tick();
      // a counter restarts once count + 1 reaches or passes its period
      if (int'(blink_cnt) + 1 >= int'(blink_period)) begin
         blink_cnt = '0;
         blink_on  = ~blink_on;
      end else begin
         blink_cnt = blink_cnt + 16'd1;
      end
      if (int'(tick_cnt) + 1 >= int'(tick_period)) begin
         tick_cnt = '0;
         if (int'(ss) + 1 >= int'(MINUTES_PER_HOUR)) begin
            ss = 6'd0;
            if (int'(mm) + 1 >= int'(MINUTES_PER_HOUR)) begin
               mm = 6'd0;
               if (int'(hh) + 1 >= int'(HOURS_PER_DAY)) hh = 5'd0;
               else hh = hh + 5'd1;
            end else begin
               mm = mm + 6'd1;
            end
         end else begin
            ss = ss + 6'd1;
         end
      end else begin
         tick_cnt = tick_cnt + 16'd1;
      end
   endfunction

   function void press_key(logic [3:0] k);
      if (k == KEY_NONE) return;
      ringing = 1'b0;   // any real key silences the alarm
      case (k)
         KEY_TIME: begin
            if (mode == MODE_SHOW) begin
               copy_clock_to_edit();
               mode = MODE_TIME;
            end
         end
         KEY_ALARM: begin
            if (mode == MODE_SHOW) mode = MODE_ALARM;
         end
         KEY_NEXT: begin
            if (mode == MODE_TIME) edit_sel = next_sel(edit_sel);
            else if (mode == MODE_ALARM) alarm_sel = next_sel(alarm_sel);
         end
         KEY_UP, KEY_DEC: begin
            if (mode == MODE_TIME)
               edit_f[edit_sel] = wrap_step(edit_f[edit_sel], edit_sel, k == KEY_UP);
            else if (mode == MODE_ALARM)
               alarm_f[alarm_sel] = wrap_step(alarm_f[alarm_sel], alarm_sel, k == KEY_UP);
         end
         KEY_SAVE: begin
            if (mode == MODE_TIME) begin
               hh = edit_f[0][4:0];
               mm = edit_f[1];
               ss = edit_f[2];
               mode = MODE_SHOW;
            end else if (mode == MODE_ALARM) begin
               mode = MODE_SHOW;
            end
         end
         KEY_CANCEL: begin
            if (mode == MODE_TIME) begin
               mode = MODE_SHOW;
               copy_clock_to_edit();
            end else if (mode == MODE_ALARM) begin
               mode = MODE_SHOW;
               alarm_f = '{6'd0, 6'd0, 6'd0};
            end
         end
         default: ;
      endcase
   endfunction

   function void accept_request(req_payload_type r);
      rsp_payload_type e;
      logic [5:0]      shown [3];
      logic [1:0]      sel;
      bit              blank;
      logic [3:0]      d [6];
      int              i;
      if (r.command == CMD_TICK) advance_tick();
      else press_key(r.key_code);
      if ({1'b0, hh} == alarm_f[0] && mm == alarm_f[1] && ss == alarm_f[2])
         ringing = 1'b1;
      shown[0] = {1'b0, hh};
      shown[1] = mm;
      shown[2] = ss;
      sel   = SEL_HOURS;
      blank = 1'b0;
      if (mode == MODE_TIME) begin
         shown = edit_f;
         sel   = edit_sel;
         blank = !blink_on;
      end else if (mode == MODE_ALARM) begin
         shown = alarm_f;
         sel   = alarm_sel;
         blank = !blink_on;
      end
      for (i = 0; i < 3; i++) begin
         if (blank && i == int'(sel)) begin
            d[2*i]   = BLANK_DIGIT;
            d[2*i+1] = BLANK_DIGIT;
         end else begin
            d[2*i]   = 4'(shown[i] / 10);
            d[2*i+1] = 4'(shown[i] % 10);
         end
      end
      e.digit_hour_tens    = d[0];
      e.digit_hour_units   = d[1];
      e.digit_minute_tens  = d[2];
      e.digit_minute_units = d[3];
      e.digit_second_tens  = d[4];
      e.digit_second_units = d[5];
      e.mode          = mode;
      e.alarm_ringing = ringing;
      e.relay_drive_n = !ringing;
      if (ringing && !blink_on)
         e.led_drive_n = (alarm_f[0] < 6'(NOON_HOUR)) ? LED_AM : LED_PM;
      else
         e.led_drive_n = LED_OFF;
      expected_displays.push_back(e);
   endfunction

   function bit same(string name, int unsigned want, int unsigned got, bit show);
      if (want != got && show)
         $display("response %0d %s: expected %0d, got %0d", n_checked, name, want, got);
      return want == got;
   endfunction

   function void check_display(rsp_payload_type got);
      rsp_payload_type want;
      bit              ok;
      bit              show;
      if (expected_displays.size() == 0) begin
         n_orphan++;
         if (n_reported < 10) begin
            n_reported++;
            $display("unexpected response transaction, nothing outstanding");
         end
         return;
      end
      want = expected_displays.pop_front();
      n_checked++;
      if (want.alarm_ringing) n_ringing++;
      show = n_reported < 10;
      ok = 1'b1;
      ok &= same("digit_hour_tens", want.digit_hour_tens, got.digit_hour_tens, show);
      ok &= same("digit_hour_units", want.digit_hour_units, got.digit_hour_units, show);
      ok &= same("digit_minute_tens", want.digit_minute_tens, got.digit_minute_tens, show);
      ok &= same("digit_minute_units", want.digit_minute_units,
                 got.digit_minute_units, show);
      ok &= same("digit_second_tens", want.digit_second_tens, got.digit_second_tens, show);
      ok &= same("digit_second_units", want.digit_second_units,
                 got.digit_second_units, show);
      ok &= same("mode", want.mode, got.mode, show);
      ok &= same("alarm_ringing", want.alarm_ringing, got.alarm_ringing, show);
      ok &= same("relay_drive_n", want.relay_drive_n, got.relay_drive_n, show);
      ok &= same("led_drive_n", want.led_drive_n, got.led_drive_n, show);
      if (!ok) begin
         n_mismatch++;
         if (show) n_reported++;
      end
   endfunction
endclass

module tb_top;

   localparam int CYCLE_LIMIT = 500000;
   localparam int N_PHASES    = 6;
   localparam int PHASE_ITEMS = 265;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_write_en;
   logic        csr_index;
   logic [15:0] csr_data;

   acts_chan_if #(.payload_type(req_payload_type)) req_chan ();
   acts_chan_if #(.payload_type(rsp_payload_type)) rsp_chan ();

   alarm_clock_with_time_setting_unit i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_chan),
      .rsp_chan     (rsp_chan),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   display_scoreboard board;

   int unsigned cycles      = 0;
   int unsigned n_sent      = 0;
   int unsigned n_settings  = 0;
   int          burst_left  = 0;
   bit          hold_off_request = 1'b0;

   // Tick and blink periods per random phase: extremes, zero, and a last
   // phase back at the reset values. Large-to-small steps leave counters
   // above the new period, which must fire on the next tick.
   logic [15:0] tick_periods  [N_PHASES] = '{16'd2, 16'd65535, 16'd0, 16'd1, 16'd3, 16'd1000};
   logic [15:0] blink_periods [N_PHASES] = '{16'd3, 16'd1, 16'd0, 16'd65535, 16'd2, 16'd250};

   always #10 clock = ~clock;

   // Watchdog
   always @(posedge clock) begin
      cycles = cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("tb_top NOT OK");
         $finish;
      end
   end

   // Sample both channels at the rising edge; the request side is noted first
   // so that a response would still find its expectation even if it came out with its request.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) board.accept_request(req_chan.payload);
         if (rsp_chan.valid && rsp_chan.ready) board.check_display(rsp_chan.payload);
      end
   end

   // Response side: the stall style is redrawn after a stretch of random length; a hold-off
   // request parks ready low for a long stretch so the block backs up.
   initial begin
      int style;
      int left;
      int hold;
      int phase_cnt;
      rsp_chan.ready = 1'b0;
      style = 0;
      left = 0;
      hold = 0;
      phase_cnt = 0;
      forever begin
         @(negedge clock);
         if (hold_off_request) begin
            hold = 300;
            hold_off_request = 1'b0;
         end
         if (left == 0) begin
            style = $urandom_range(0, 3);
            left  = $urandom_range(20, 200);
         end
         left--;
         phase_cnt++;
         if (hold > 0) begin
            hold--;
            rsp_chan.ready <= 1'b0;
         end else begin
            case (style)
               0: rsp_chan.ready <= 1'b1;
               1: rsp_chan.ready <= 1'($urandom_range(0, 1));
               2: rsp_chan.ready <= (phase_cnt % 5 == 0);
               default: rsp_chan.ready <= ($urandom_range(0, 9) != 0);
            endcase
         end
      end
   end

   // One request transaction; called and returning at a falling edge.
   // Bursts of random length, separated by random gaps.
   task automatic offer(input logic cmd, input logic [3:0] key);
      req_payload_type item;
      int gap;
      item.command  = cmd;
      item.key_code = key;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 40);
      end
      burst_left--;
      req_chan.valid   <= 1'b1;
      req_chan.payload <= item;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      @(negedge clock);
      n_sent++;
   endtask

   task automatic tick();
      offer(CMD_TICK, 4'($urandom_range(0, 15)));
   endtask

   // Drop valid and wait until every display has come back.
   task automatic drain();
      req_chan.valid <= 1'b0;
      burst_left = 0;
      while (board.expected_displays.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_register(input logic idx, input logic [15:0] value);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_data     <= value;
      @(negedge clock);
      board.set_register(idx, value);
      csr_write_en <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_periods(input logic [15:0] tps, input logic [15:0] bhp);
      write_register(CSR_TICKS_PER_SECOND, tps);
      write_register(CSR_BLINK_HALF_PERIOD, bhp);
      n_settings++;
   endtask

   // Editing session in time or alarm mode with random content.
   task automatic edit_session(input logic [3:0] enter_key);
      int r;
      if (board.mode != MODE_SHOW) offer(CMD_KEY, KEY_SAVE);
      offer(CMD_KEY, enter_key);
      repeat ($urandom_range(1, 14)) begin
         r = $urandom_range(0, 9);
         if (r <= 1) offer(CMD_KEY, KEY_NEXT);
         else if (r <= 4) repeat ($urandom_range(1, 6)) offer(CMD_KEY, KEY_UP);
         else if (r <= 7) repeat ($urandom_range(1, 6)) offer(CMD_KEY, KEY_DEC);
         else if (r == 8) tick();
         else offer(CMD_KEY, 4'($urandom_range(0, 15)));
      end
      // alarm sessions mostly keep their result so the alarm can go off
      if (enter_key == KEY_ALARM)
         offer(CMD_KEY, ($urandom_range(0, 3) != 0) ? KEY_SAVE : KEY_CANCEL);
      else
         offer(CMD_KEY, ($urandom_range(0, 1) != 0) ? KEY_SAVE : KEY_CANCEL);
   endtask

   // Set the alarm a second or three ahead of the clock, then tick into it.
   task automatic chase_alarm();
      logic [5:0] goal [3];
      int f;
      int lim;
      int diff;
      int n_ticks;
      if (board.mode != MODE_SHOW) offer(CMD_KEY, KEY_SAVE);
      goal[0] = {1'b0, board.hh};
      goal[1] = board.mm;
      goal[2] = 6'((int'(board.ss) + $urandom_range(1, 3)) % 60);
      offer(CMD_KEY, KEY_ALARM);
      for (f = 0; f < 3; f++) begin
         lim = (f == 0) ? int'(HOURS_PER_DAY) : int'(MINUTES_PER_HOUR);
         while (int'(board.alarm_sel) != f) offer(CMD_KEY, KEY_NEXT);
         while (board.alarm_f[f] != goal[f]) begin
            diff = (int'(goal[f]) - int'(board.alarm_f[f]) + lim) % lim;
            offer(CMD_KEY, (diff <= lim / 2) ? KEY_UP : KEY_DEC);
         end
      end
      offer(CMD_KEY, KEY_SAVE);
      n_ticks = (board.tick_period <= 16'd3) ? int'(board.tick_period) * 4 + 4 : 12;
      repeat (n_ticks) tick();
   endtask

   task automatic random_phase(input int budget);
      int unsigned start;
      int r;
      start = n_sent;
      while (n_sent - start < budget) begin
         r = $urandom_range(0, 9);
         if (r <= 2) edit_session(KEY_TIME);
         else if (r <= 4) edit_session(KEY_ALARM);
         else if (r == 5) chase_alarm();
         else if (r <= 7) repeat ($urandom_range(1, 30)) tick();
         else repeat ($urandom_range(1, 8))
            offer(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
      end
   endtask

   initial begin
      int p;
      reset            = 1'b1;
      req_chan.valid   = 1'b0;
      req_chan.payload = '0;
      csr_write_en     = 1'b0;
      csr_index        = CSR_TICKS_PER_SECOND;
      csr_data         = '0;
      board = new();

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: one-tick seconds from 23:59:55 roll over into the default
      // 00:00:00 alarm, then every key in and out of both setting modes.
      set_periods(16'd1, 16'd1);
      offer(CMD_TICK, 4'd15);
      offer(CMD_TICK, KEY_NONE);
      tick();
      tick();
      tick();              // midnight, alarm goes off
      tick();
      offer(CMD_KEY, 4'd4);    // silences only
      offer(CMD_KEY, KEY_NONE);
      offer(CMD_KEY, 4'd9);
      offer(CMD_KEY, 4'd15);
      offer(CMD_KEY, KEY_TIME);
      offer(CMD_KEY, KEY_ALARM);   // ignored outside show mode
      offer(CMD_KEY, KEY_NEXT);
      offer(CMD_KEY, KEY_UP);
      offer(CMD_KEY, KEY_DEC);
      offer(CMD_KEY, KEY_DEC);     // wraps below zero
      offer(CMD_KEY, KEY_SAVE);
      offer(CMD_KEY, KEY_ALARM);
      offer(CMD_KEY, KEY_NEXT);
      offer(CMD_KEY, KEY_NEXT);
      offer(CMD_KEY, KEY_DEC);     // seconds 0 -> 59
      offer(CMD_KEY, KEY_NEXT);    // selector wraps to hours
      offer(CMD_KEY, KEY_UP);
      offer(CMD_KEY, KEY_CANCEL);  // clears the alarm
      offer(CMD_KEY, KEY_TIME);
      offer(CMD_KEY, KEY_CANCEL);
      drain();

      for (p = 0; p < N_PHASES; p++) begin
         set_periods(tick_periods[p], blink_periods[p]);
         if (p == 0 || p == 3) hold_off_request = 1'b1;
         random_phase(PHASE_ITEMS);
         drain();
      end

      repeat (10) @(negedge clock);
      $display("run: %0d requests, %0d displays checked, %0d with the alarm ringing",
               n_sent, board.n_checked, board.n_ringing);
      $display("run: %0d period settings, %0d mismatching and %0d stray responses",
               n_settings, board.n_mismatch, board.n_orphan);
      if (board.n_mismatch == 0 && board.n_orphan == 0 &&
          board.expected_displays.size() == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end

endmodule

`default_nettype wire

### filelist.f
hw/rtl/acts_pkg.sv
hw/rtl/acts_chan_if.sv
hw/rtl/alarm_clock_with_time_setting_unit.sv
sim/tb_top.sv
